@@ rtl/cbf_pkg.sv @@
// Package for the counting Bloom filter: operation codes, register indexes,
// controller states and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package cbf_pkg;

   // Fixed field widths of the ports.
   localparam int HASH_W        = 32;
   localparam int NUM_CELLS_W   = 13;
   localparam int NUM_PROBES_W  = 5;
   localparam int CSR_DATA_W    = 13;
   localparam int CSR_INDEX_W   = 1;

   // Largest value the register fields can hold.
   localparam int NUM_CELLS_MAX  = (1 << NUM_CELLS_W) - 1;
   localparam int NUM_PROBES_MAX = (1 << NUM_PROBES_W) - 1;

   // Reset values of the registers.
   localparam logic [NUM_CELLS_W-1:0]  NUM_CELLS_RESET  = 13'd4096;
   localparam logic [NUM_PROBES_W-1:0] NUM_PROBES_RESET = 5'd4;

   // The modulo reduction retires two hash bits per cycle.
   localparam int RED_BITS_PER_STEP = 2;
   localparam int RED_STEPS         = HASH_W / RED_BITS_PER_STEP;
   localparam int RED_CNT_W         = $clog2(RED_STEPS);
   localparam logic [RED_CNT_W-1:0] RED_LAST = RED_CNT_W'(RED_STEPS - 1);

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_QUERY  = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SATURATED = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NUM_CELLS  = 1'b0,
      CSR_NUM_PROBES = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_READ,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;    // write zero to the next cell of the clearing pass
      logic load;     // capture an accepted item
      logic reduce;   // one step of the hash reductions
      logic update;   // read-modify-write of the current probe cell
      logic finish;   // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;   // clearing pass is at its last cell
      logic probe_last;   // current probe is the last one of the item
   } stat_type;

endpackage

`default_nettype wire

@@ rtl/cbf_if.sv @@
// Handshake channels of the counting Bloom filter: request and response.
// Depends on cbf_pkg for the field widths.
`default_nettype none

interface cbf_req_if
   import cbf_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [1:0]        mode;
   logic [HASH_W-1:0] first_hash;
   logic [HASH_W-1:0] second_hash;

   modport source (output valid, output mode, output first_hash, output second_hash,
                   input ready);
   modport sink   (input valid, input mode, input first_hash, input second_hash,
                   output ready);
endinterface

interface cbf_rsp_if;
   logic       valid;
   logic       ready;
   logic       present;
   logic [1:0] status;

   modport source (output valid, output present, output status, input ready);
   modport sink   (input valid, input present, input status, output ready);
endinterface

`default_nettype wire

@@ rtl/counting_bloom_filter_core.sv @@
// Top level of the counting Bloom filter with double hashing.
// Depends on cbf_pkg, cbf_if, cbf_ctrl and cbf_dp.
//
//  Channel    Direction  Payload                          Handshake
//  req_chan   in         mode, first_hash, second_hash    valid/ready
//  rsp_chan   out        present, status                  valid/ready
//  csr_*      in         csr_index, csr_wdata             csr_we, no wait
//
// An item passes through these steps, k being the probe count: acceptance, the
// two hash reductions (two bits per cycle), a read and a write-back of the
// counter memory for each of the k probes, and the load of the result register.
// After reset a clearing pass zeroes the counters, one cell a cycle; no item is
// accepted until it ends.
// A new item is accepted while a result is still waiting on rsp_chan; that item
// stalls at its end until the waiting result has been taken.
`default_nettype none

module counting_bloom_filter_core
   import cbf_pkg::*;
#(
   parameter int CELL_COUNT   = 4096,
   parameter int COUNTER_BITS = 4,
   parameter int MAX_PROBES   = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   cbf_req_if.sink                     req_chan,
   cbf_rsp_if.source                   rsp_chan,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   // Sequencer.
   cbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Arithmetic, counter memory and result.
   cbf_dp #(
      .CELL_COUNT   (CELL_COUNT),
      .COUNTER_BITS (COUNTER_BITS),
      .MAX_PROBES   (MAX_PROBES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_mode        (req_chan.mode),
      .req_first_hash  (req_chan.first_hash),
      .req_second_hash (req_chan.second_hash),
      .rsp_present     (rsp_chan.present),
      .rsp_status      (rsp_chan.status)
   );

endmodule

`default_nettype wire

@@ rtl/cbf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module cbf_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/cbf_ctrl.sv @@
// Controller of the counting Bloom filter: sequences clearing, hash reduction,
// probe read-modify-writes and result delivery. Depends on cbf_pkg.
`default_nettype none

module cbf_ctrl
   import cbf_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output      logic     req_ready,
   output      logic     rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type stat,
   output      cmd_type  cmd
);

   state_type            state_ff, state_in;
   logic [RED_CNT_W-1:0] red_cnt_ff, red_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // State, step counter and result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         red_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         red_cnt_ff   <= red_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      red_cnt_in   = red_cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load   = 1'b1;
               red_cnt_in = '0;
               state_in   = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            red_cnt_in = red_cnt_ff + 1'b1;
            if (red_cnt_ff == RED_LAST) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // The memory samples the probe address at this edge.
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = stat.probe_last ? ST_FINISH : ST_READ;
         end
         ST_FINISH: begin
            // Hold the result until the previous one has been taken.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ rtl/cbf_dp.sv @@
// Datapath of the counting Bloom filter: configuration registers, modulo reduction,
// probe index stepping, counter memory and result register.
// Depends on cbf_pkg and cbf_ram.
`default_nettype none

module cbf_dp
   import cbf_pkg::*;
#(
   parameter int CELL_COUNT   = 4096,
   parameter int COUNTER_BITS = 4,
   parameter int MAX_PROBES   = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output      stat_type               stat,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic [1:0]             req_mode,
   input  wire logic [HASH_W-1:0]      req_first_hash,
   input  wire logic [HASH_W-1:0]      req_second_hash,
   output      logic                   rsp_present,
   output      logic [1:0]             rsp_status
);

   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CELLS_CAP  = (CELL_COUNT < NUM_CELLS_MAX) ? CELL_COUNT : NUM_CELLS_MAX;
   localparam int PROBES_CAP = (MAX_PROBES < NUM_PROBES_MAX) ? MAX_PROBES : NUM_PROBES_MAX;
   localparam int PROBE_W    = (PROBES_CAP > 1) ? $clog2(PROBES_CAP) : 1;

   localparam logic [NUM_CELLS_W-1:0]  CELLS_CAP_V  = NUM_CELLS_W'(CELLS_CAP);
   localparam logic [NUM_PROBES_W-1:0] PROBES_CAP_V = NUM_PROBES_W'(PROBES_CAP);
   localparam logic [ADDR_W-1:0]       CLEAR_LAST   = ADDR_W'(CELL_COUNT - 1);
   localparam logic [COUNTER_BITS-1:0] COUNTER_MAX  = '1;

   // One restoring step of a remainder: shift in a bit, subtract the modulus if it fits.
   function automatic logic [NUM_CELLS_W-1:0] mod_shift(input logic [NUM_CELLS_W-1:0] rem,
                                                        input logic bit_in,
                                                        input logic [NUM_CELLS_W-1:0] m);
      logic [NUM_CELLS_W:0] t;
      t = {rem, bit_in};
      if (t >= {1'b0, m}) begin
         t = t - {1'b0, m};
      end
      return t[NUM_CELLS_W-1:0];
   endfunction

   logic [NUM_CELLS_W-1:0]  num_cells_ff;
   logic [NUM_PROBES_W-1:0] num_probes_ff;
   logic [NUM_CELLS_W-1:0]  cells_used;
   logic [NUM_PROBES_W-1:0] probes_clamped;
   logic [PROBE_W-1:0]      probe_last_idx;

   mode_type                mode_ff;
   logic [HASH_W-1:0]       h1_ff, h2_ff;
   logic [NUM_CELLS_W-1:0]  idx_ff, idx_in;
   logic [NUM_CELLS_W-1:0]  stride_ff;
   logic [NUM_CELLS_W:0]    idx_sum;
   logic [PROBE_W-1:0]      probe_cnt_ff;
   logic                    present_ff, sat_ff, undr_ff;
   logic                    rsp_present_ff;
   status_type              rsp_status_ff;
   logic [ADDR_W-1:0]       clr_addr_ff;

   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_waddr;
   logic [COUNTER_BITS-1:0] ram_wdata;
   logic [COUNTER_BITS-1:0] ram_rdata;
   logic                    upd_we;
   logic [COUNTER_BITS-1:0] upd_val;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_cells_ff  <= NUM_CELLS_RESET;
         num_probes_ff <= NUM_PROBES_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NUM_CELLS:  num_cells_ff  <= csr_wdata;
            CSR_NUM_PROBES: num_probes_ff <= csr_wdata[NUM_PROBES_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective modulus and probe count after clamping.
   always_comb begin
      if (num_cells_ff == '0) begin
         cells_used = NUM_CELLS_W'(1);
      end else if (num_cells_ff > CELLS_CAP_V) begin
         cells_used = CELLS_CAP_V;
      end else begin
         cells_used = num_cells_ff;
      end
      if (num_probes_ff == '0) begin
         probes_clamped = NUM_PROBES_W'(1);
      end else if (num_probes_ff > PROBES_CAP_V) begin
         probes_clamped = PROBES_CAP_V;
      end else begin
         probes_clamped = num_probes_ff;
      end
      probe_last_idx = PROBE_W'(probes_clamped - 1'b1);
   end

   // Next probe index: add the stride and wrap once.
   always_comb begin
      idx_sum = {1'b0, idx_ff} + {1'b0, stride_ff};
      if (idx_sum >= {1'b0, cells_used}) begin
         idx_sum = idx_sum - {1'b0, cells_used};
      end
      idx_in = idx_sum[NUM_CELLS_W-1:0];
   end

   // Counter update for the current probe.
   always_comb begin
      upd_we  = 1'b0;
      upd_val = ram_rdata;
      case (mode_ff)
         MODE_INSERT: begin
            if (ram_rdata != COUNTER_MAX) begin
               upd_we  = 1'b1;
               upd_val = ram_rdata + 1'b1;
            end
         end
         MODE_REMOVE: begin
            if (ram_rdata != '0) begin
               upd_we  = 1'b1;
               upd_val = ram_rdata - 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Item registers: hash shifters, remainders, probe index and flags.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff      <= mode_type'(req_mode);
         h1_ff        <= req_first_hash;
         h2_ff        <= req_second_hash;
         idx_ff       <= '0;
         stride_ff    <= '0;
         probe_cnt_ff <= '0;
         present_ff   <= 1'b1;
         sat_ff       <= 1'b0;
         undr_ff      <= 1'b0;
      end else if (cmd.reduce) begin
         idx_ff    <= mod_shift(mod_shift(idx_ff, h1_ff[HASH_W-1], cells_used),
                                h1_ff[HASH_W-2], cells_used);
         stride_ff <= mod_shift(mod_shift(stride_ff, h2_ff[HASH_W-1], cells_used),
                                h2_ff[HASH_W-2], cells_used);
         h1_ff     <= h1_ff << RED_BITS_PER_STEP;
         h2_ff     <= h2_ff << RED_BITS_PER_STEP;
      end else if (cmd.update) begin
         idx_ff       <= idx_in;
         probe_cnt_ff <= probe_cnt_ff + 1'b1;
         if (mode_ff == MODE_INSERT && ram_rdata == COUNTER_MAX) begin
            sat_ff <= 1'b1;
         end
         if (mode_ff == MODE_REMOVE && ram_rdata == '0) begin
            undr_ff <= 1'b1;
         end
         if (mode_ff == MODE_QUERY && ram_rdata == '0) begin
            present_ff <= 1'b0;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_present_ff <= (mode_ff == MODE_QUERY) & present_ff;
         if (sat_ff) begin
            rsp_status_ff <= STATUS_SATURATED;
         end else if (undr_ff) begin
            rsp_status_ff <= STATUS_UNDERFLOW;
         end else begin
            rsp_status_ff <= STATUS_OK;
         end
      end
   end

   // Clearing pass address.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // Counter memory.
   assign ram_we    = cmd.clear | (cmd.update & upd_we);
   assign ram_waddr = cmd.clear ? clr_addr_ff : ADDR_W'(idx_ff);
   assign ram_wdata = cmd.clear ? '0 : upd_val;

   cbf_ram #(
      .WIDTH (COUNTER_BITS),
      .DEPTH (CELL_COUNT)
   ) u_counters (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ADDR_W'(idx_ff)),
      .rd_data (ram_rdata)
   );

   assign stat.clear_last = (clr_addr_ff == CLEAR_LAST);
   assign stat.probe_last = (probe_cnt_ff == probe_last_idx);
   assign rsp_present     = rsp_present_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

`default_nettype wire

@@ test/cbf_checker.sv @@
// Scoreboard for the counting Bloom filter: watches the request, response and
// register ports, keeps its own copy of the counters, and checks every result.
// Depends on cbf_pkg and the channel interfaces in cbf_if.
`timescale 1ns / 1ps

module cbf_checker
   import cbf_pkg::*;
#(
   parameter int CELL_COUNT   = 4096,
   parameter int COUNTER_BITS = 4,
   parameter int MAX_PROBES   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   cbf_req_if                     req_mon,
   cbf_rsp_if                     rsp_mon,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     failures,
   output int                     pending
);

   typedef struct packed {
      logic       present;
      status_type status;
   } answer_type;

   // Shadow copy of the counter memory and the two registers.
   logic [COUNTER_BITS-1:0] counters [CELL_COUNT];
   logic [NUM_CELLS_W-1:0]  cells_reg;
   logic [NUM_PROBES_W-1:0] probes_reg;
   answer_type              pending_answers [$];

   // Walks the probe sequence of one key, updates the shadow counters and
   // returns the answer the block should give for it.
   function automatic answer_type probe_counters(mode_type op, logic [HASH_W-1:0] h1,
                                                 logic [HASH_W-1:0] h2);
      int unsigned             m;
      int unsigned             k;
      int unsigned             pos;
      int unsigned             stride;
      logic [COUNTER_BITS-1:0] c;
      answer_type              ans;

      ans.present = (op == MODE_QUERY);
      ans.status  = STATUS_OK;
      if (op == MODE_NONE) begin
         ans.present = 1'b0;
         return ans;
      end

      // Out-of-range register values are clamped into the usable range.
      m = cells_reg;
      if (m == 0) m = 1;
      if (m > CELL_COUNT) m = CELL_COUNT;
      k = probes_reg;
      if (k == 0) k = 1;
      if (k > MAX_PROBES) k = MAX_PROBES;

      pos    = h1 % m;
      stride = h2 % m;
      for (int unsigned i = 0; i < k; i++) begin
         c = counters[pos];
         case (op)
            MODE_INSERT: begin
               if (c == '1) ans.status = STATUS_SATURATED;
               else counters[pos] = c + 1'b1;
            end
            MODE_REMOVE: begin
               if (c == '0) ans.status = STATUS_UNDERFLOW;
               else counters[pos] = c - 1'b1;
            end
            default: begin
               if (c == '0) ans.present = 1'b0;
            end
         endcase
         pos = (pos + stride) % m;
      end
      return ans;
   endfunction

   // Results are retired before new items are predicted, so an item accepted
   // on the same edge never pairs with its own result.
   always @(posedge clock) begin
      answer_type want;

      if (reset) begin
         for (int j = 0; j < CELL_COUNT; j++) counters[j] = '0;
         cells_reg  = NUM_CELLS_RESET;
         probes_reg = NUM_PROBES_RESET;
         pending_answers.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_NUM_CELLS:  cells_reg  = csr_wdata[NUM_CELLS_W-1:0];
               CSR_NUM_PROBES: probes_reg = csr_wdata[NUM_PROBES_W-1:0];
               default: ;
            endcase
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_answers.size() == 0) begin
               $error("unexpected result: present=%0d status=%0d",
                      rsp_mon.present, rsp_mon.status);
               failures++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_mon.present !== want.present) begin
                  $error("present: expected %0d, got %0d", want.present, rsp_mon.present);
                  failures++;
               end
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
                  failures++;
               end
            end
         end

         if (req_mon.valid && req_mon.ready)
            pending_answers.push_back(probe_counters(mode_type'(req_mon.mode),
                                                     req_mon.first_hash,
                                                     req_mon.second_hash));
      end
      pending <= pending_answers.size();
   end

endmodule

@@ test/tb.sv @@
// Top of the counting Bloom filter testbench: clock, reset, request and
// register stimulus, response back-pressure and the final verdict.
// Depends on cbf_pkg, cbf_if, counting_bloom_filter_core and cbf_checker.
`timescale 1ns / 1ps

module tb;
   import cbf_pkg::*;

   localparam int NUM_PHASES  = 8;
   localparam int PHASE_ITEMS = 110;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   quiet = 1'b0;
   int                     failures;
   int                     pending;
   logic [2*HASH_W-1:0]    key_pool [$];

   // Register settings per phase, extremes included: zero and oversized values
   // get clamped by the block.
   int phase_cells  [NUM_PHASES] = '{1, 8191, 0, 16, 4096, 7, 300, 4095};
   int phase_probes [NUM_PHASES] = '{0, 31, 16, 3, 1, 5, 8, 2};

   cbf_req_if req_chan ();
   cbf_rsp_if rsp_chan ();

   counting_bloom_filter_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cbf_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_chan),
      .rsp_mon   (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .failures  (failures),
      .pending   (pending)
   );

   always #4 clock = ~clock;

   // Presents one item and holds it until the block takes it.
   task automatic send_item(input mode_type op, input logic [HASH_W-1:0] h1,
                            input logic [HASH_W-1:0] h2);
      req_chan.valid       <= 1'b1;
      req_chan.mode        <= op;
      req_chan.first_hash  <= h1;
      req_chan.second_hash <= h2;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Stops sending and waits until every outstanding result has come back.
   // The first edge lets the count catch up with the last accepted item.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Both registers are written on back-to-back edges with the enable held.
   task automatic write_config(input int cells, input int probes);
      csr_we    <= 1'b1;
      csr_index <= CSR_NUM_CELLS;
      csr_wdata <= cells[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index <= CSR_NUM_PROBES;
      csr_wdata <= {8'($urandom_range(0, 255)), probes[NUM_PROBES_W-1:0]};
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Hash words biased toward the extremes and small values.
   function automatic logic [HASH_W-1:0] random_word();
      case ($urandom_range(0, 4))
         0:       return ($urandom_range(0, 1) == 1) ? '1 : '0;
         1:       return HASH_W'($urandom_range(0, 64));
         default: return $urandom();
      endcase
   endfunction

   // Mostly inserts, removes and queries on recently inserted keys, so that
   // queries hit and removes find live counters; the rest is fresh keys.
   task automatic random_item();
      int          pick;
      mode_type    op;
      logic [HASH_W-1:0] h1;
      logic [HASH_W-1:0] h2;

      pick = $urandom_range(0, 99);
      if (pick < 40) op = MODE_INSERT;
      else if (pick < 65) op = MODE_REMOVE;
      else if (pick < 95) op = MODE_QUERY;
      else op = MODE_NONE;

      if (key_pool.size() > 0 && $urandom_range(0, 2) != 0) begin
         {h1, h2} = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end else begin
         h1 = random_word();
         h2 = random_word();
         if (op == MODE_INSERT) begin
            key_pool.push_back({h1, h2});
            if (key_pool.size() > 12) void'(key_pool.pop_front());
         end
      end
      send_item(op, h1, h2);
   endtask

   // Response back-pressure: random stall bursts between ready stretches,
   // always ready during reset and in the quiet tail of the run.
   initial begin
      int stall_left;
      int run_left;

      stall_left     = 0;
      run_left       = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset || quiet) begin
            rsp_chan.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (run_left > 0) begin
            run_left--;
            rsp_chan.ready <= 1'b1;
         end else if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            run_left = $urandom_range(0, 40);
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.mode        = MODE_INSERT;
      req_chan.first_hash  = '0;
      req_chan.second_hash = '0;
      csr_we               = 1'b0;
      csr_index            = CSR_NUM_CELLS;
      csr_wdata            = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed items at the reset setting: hits and misses, hash extremes,
      // a key whose stride folds to zero so that one cell saturates and then
      // underflows, and the unused mode.
      send_item(MODE_INSERT, '0, '0);
      send_item(MODE_QUERY, '0, '0);
      send_item(MODE_QUERY, 32'd1, 32'd1);
      send_item(MODE_INSERT, '1, '1);
      send_item(MODE_QUERY, '1, '1);
      send_item(MODE_REMOVE, '1, '1);
      send_item(MODE_REMOVE, '1, '1);
      send_item(MODE_QUERY, '1, '1);
      repeat (4) send_item(MODE_INSERT, 32'd5, 32'd0);
      send_item(MODE_QUERY, 32'd5, 32'd4096);
      send_item(MODE_NONE, 32'd5, 32'd0);
      repeat (4) send_item(MODE_REMOVE, 32'd5, 32'd4096);
      send_item(MODE_INSERT, 32'h8000_0000, 32'h5555_5555);
      send_item(MODE_QUERY, 32'h8000_0000, 32'h5555_5555);
      send_item(MODE_QUERY, 32'hAAAA_AAAA, 32'h0000_0001);
      send_item(MODE_NONE, '1, '0);
      drain_results();

      // Random phases, each under its own register setting; the last phase
      // runs without idling on either side.
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_config(phase_cells[p], phase_probes[p]);
         key_pool.delete();
         quiet = (p == NUM_PHASES - 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
               req_chan.valid <= 1'b0;
               repeat ($urandom_range(1, 15)) @(posedge clock);
            end
            random_item();
            if (p == 3 && n == PHASE_ITEMS / 2) drain_results();
         end
         drain_results();
      end

      repeat (60) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/cbf_pkg.sv
rtl/cbf_if.sv
rtl/cbf_ram.sv
rtl/cbf_ctrl.sv
rtl/cbf_dp.sv
rtl/counting_bloom_filter_core.sv
test/cbf_checker.sv
test/tb.sv
